// ===== rtl/core/rhsv_pkg.sv =====
// Shared types, widths and constants for the RGB to HSV converter.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int CHAN_W = 8;
    localparam int QUO_W  = 15;
    localparam int NUM_W  = CHAN_W + QUO_W;
    localparam int HUE_W  = 15;
    localparam int PCT_W  = 13;

    localparam logic [NUM_W-1:0]  HUE_FULL_TURN = NUM_W'(23040);
    localparam logic [NUM_W-1:0]  HUE_SIXTH     = NUM_W'(3840);
    localparam logic [NUM_W-1:0]  PCT_FULL      = NUM_W'(6400);
    localparam logic [QUO_W-1:0]  HUE_WRAP      = QUO_W'(23040);
    // Whole part of 6400 / 255; the remainder of that division is also 25.
    localparam logic [PCT_W-1:0]  VAL_STEP      = PCT_W'(6400 / 255);

    // One division lane: the partial remainder, the divisor, and a shift
    // register holding the unused numerator bits above the quotient bits.
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] den;
        logic [QUO_W-1:0]  acc;
    } t_lane;

    // The value field is finished in the front stage and only carried along.
    typedef struct packed {
        t_lane            hue;
        t_lane            sat;
        logic [PCT_W-1:0] val;
    } t_word;

endpackage

// ===== rtl/core/rhsv_front.sv =====
// Front stage: maximum, minimum and range of the pixel, the dividends and
// divisors loaded into the division chain, and the finished value. Uses rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_front
    import rhsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    output logic              o_valid,
    output t_word             o_word
);

    logic [CHAN_W-1:0] w_hi;
    logic [CHAN_W-1:0] w_lo;
    logic [CHAN_W-1:0] w_span;
    logic [NUM_W-1:0]  w_hue_num;
    logic [NUM_W-1:0]  w_sat_num;
    logic [PCT_W-1:0]  w_val;
    logic [CHAN_W-1:0] w_hue_den;
    logic [CHAN_W-1:0] w_sat_den;
    t_word             n_word;
    logic              r_valid;
    t_word             r_word;

    function automatic t_lane load_lane(input logic [NUM_W-1:0] num,
                                        input logic [CHAN_W-1:0] den);
        t_lane l;
        l.rem = num[NUM_W-1:QUO_W];
        l.den = den;
        l.acc = num[QUO_W-1:0];
        return l;
    endfunction

    always_comb begin
        logic [CHAN_W-1:0] m;
        logic [NUM_W-1:0]  r_x;
        logic [NUM_W-1:0]  g_x;
        logic [NUM_W-1:0]  b_x;
        logic [NUM_W-1:0]  s_x;
        logic [PCT_W-1:0]  v_x;
        m    = (i_red > i_green) ? i_red : i_green;
        w_hi = (m > i_blue) ? m : i_blue;
        m    = (i_red < i_green) ? i_red : i_green;
        w_lo = (m < i_blue) ? m : i_blue;
        w_span = w_hi - w_lo;

        r_x = NUM_W'(i_red);
        g_x = NUM_W'(i_green);
        b_x = NUM_W'(i_blue);
        s_x = NUM_W'(w_span);

        // The sums are taken modulo 2^NUM_W; the true value is always
        // non-negative and fits, so the wrap-around cancels.
        if (w_hi == i_red) begin
            w_hue_num = HUE_FULL_TURN * s_x + HUE_SIXTH * g_x - HUE_SIXTH * b_x;
        end else if (w_hi == i_green) begin
            w_hue_num = (HUE_SIXTH << 1) * s_x + HUE_SIXTH * b_x - HUE_SIXTH * r_x;
        end else begin
            w_hue_num = (HUE_SIXTH << 2) * s_x + HUE_SIXTH * r_x - HUE_SIXTH * g_x;
        end
        w_hue_den = w_span;
        w_sat_num = PCT_FULL * s_x;
        w_sat_den = w_hi;

        // Since 6400 = 25 * 255 + 25, the value is 25 * hi plus the floor of
        // 25 * hi / 255, and that small quotient is exact with two shifts.
        v_x   = VAL_STEP * PCT_W'(w_hi);
        w_val = v_x + ((v_x + (v_x >> 8) + PCT_W'(1)) >> 8);

        // A zero divisor is replaced by one over a zero dividend, which
        // gives the required zero quotient.
        if (w_span == '0) begin
            w_hue_num = '0;
            w_hue_den = CHAN_W'(1);
        end
        if (w_hi == '0) begin
            w_sat_num = '0;
            w_sat_den = CHAN_W'(1);
        end

        n_word.hue = load_lane(w_hue_num, w_hue_den);
        n_word.sat = load_lane(w_sat_num, w_sat_den);
        n_word.val = w_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/core/rhsv_div_cell.sv =====
// One cell of the division chain: a single restoring step on the hue and
// saturation lanes, one quotient bit per lane; the value is passed on. Uses rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_div_cell
    import rhsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    t_word n_word;
    logic  r_valid;
    t_word r_word;

    function automatic t_lane step(input t_lane l);
        t_lane             s;
        logic [CHAN_W:0]   trial;
        logic              ge;
        trial = {l.rem, l.acc[QUO_W-1]};
        ge    = (trial >= {1'b0, l.den});
        s.den = l.den;
        // The remainder stays below the divisor, so it fits in CHAN_W bits.
        s.rem = ge ? CHAN_W'(trial - {1'b0, l.den}) : trial[CHAN_W-1:0];
        s.acc = {l.acc[QUO_W-2:0], ge};
        return s;
    endfunction

    always_comb begin
        n_word.hue = step(i_word.hue);
        n_word.sat = step(i_word.sat);
        n_word.val = i_word.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/core/rhsv_out_skid.sv =====
// Output stage: hue wrap-around, output register and skid register.
// Uses rhsv_pkg; fed by the last cell of the division chain.
`timescale 1ns / 1ps

module rhsv_out_skid
    import rhsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_word            i_word,
    output logic             o_en,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [HUE_W-1:0] o_hue,
    output logic [PCT_W-1:0] o_sat,
    output logic [PCT_W-1:0] o_val
);

    logic [HUE_W-1:0] w_hue;
    logic             w_in_fire;
    logic             w_out_free;
    logic             r_out_valid;
    logic [HUE_W-1:0] r_out_hue;
    logic [PCT_W-1:0] r_out_sat;
    logic [PCT_W-1:0] r_out_val;
    logic             r_skid_valid;
    logic [HUE_W-1:0] r_skid_hue;
    logic [PCT_W-1:0] r_skid_sat;
    logic [PCT_W-1:0] r_skid_val;

    assign w_hue = (i_word.hue.acc >= HUE_WRAP) ? HUE_W'(i_word.hue.acc - HUE_WRAP)
                                                : HUE_W'(i_word.hue.acc);

    // The chain only stops once the skid register is occupied.
    assign o_en       = !r_skid_valid;
    assign w_in_fire  = i_valid && o_en;
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid  <= r_skid_valid || w_in_fire;
                r_skid_valid <= 1'b0;
            end else if (w_in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_hue <= r_skid_hue;
                r_out_sat <= r_skid_sat;
                r_out_val <= r_skid_val;
            end else begin
                r_out_hue <= w_hue;
                r_out_sat <= i_word.sat.acc[PCT_W-1:0];
                r_out_val <= i_word.val;
            end
        end
        if (!w_out_free && w_in_fire) begin
            r_skid_hue <= w_hue;
            r_skid_sat <= i_word.sat.acc[PCT_W-1:0];
            r_skid_val <= i_word.val;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hue   = r_out_hue;
    assign o_sat   = r_out_sat;
    assign o_val   = r_out_val;

endmodule

// ===== rtl/core/rgb_to_hsv_converter_top.sv =====
// Top level of the RGB to HSV converter: front stage, a chain of fifteen
// division cells and the output skid stage. Uses rhsv_pkg and all rhsv_ modules.
//
//  Port group   Direction  Handshake                  Payload
//  pixel in     input      i_in_valid / o_in_ready    i_red, i_green, i_blue
//  result out   output     o_out_valid / i_out_ready  o_hue, o_saturation, o_brightness
//
// One word is accepted per clock while o_in_ready is high; a word passes the
// front stage, one cell per quotient bit, then the output register.
// Reset clears every valid flag; payload registers are not reset.
// A stall on the output lets one more word into the skid register; o_in_ready
// falls in the cycle the skid register fills, and the chain halts with it.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top
    import rhsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [HUE_W-1:0]  o_hue,
    output logic [PCT_W-1:0]  o_saturation,
    output logic [PCT_W-1:0]  o_brightness
);

    logic  w_en;
    logic  w_valid [0:QUO_W];
    t_word w_word  [0:QUO_W];

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_valid[0]),
        .o_word  (w_word[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        rhsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    rhsv_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[QUO_W]),
        .i_word  (w_word[QUO_W]),
        .o_en    (w_en),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_hue   (o_hue),
        .o_sat   (o_saturation),
        .o_val   (o_brightness)
    );

    assign o_in_ready = w_en;

endmodule
